[hw/rtl/sida_pkg.sv]
// ----------------------------------------------------------------------------
// sida_pkg: shared constants and types for the decimal text converter
// Widths, ASCII codes and the control structs passed between modules.
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int VALUE_BITS = 32;
    // decimal digits of the largest magnitude, 2**(VALUE_BITS-1)
    // (1233/4096 approximates log10(2) closely enough over the whole range)
    localparam int DIGITS     = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } t_dab_ctrl;

    typedef struct packed {
        logic valid;
        logic sign;
        logic last;
    } t_emit;

endpackage

[hw/rtl/sida_dabble.sv]
// ----------------------------------------------------------------------------
// sida_dabble: bit-serial binary to BCD converter
// Shift-and-add-3 over the magnitude, one bit per cycle, then shifts the
// BCD digits out most significant first, one digit per cycle.
// ----------------------------------------------------------------------------
module sida_dabble (
    input  logic                                i_clk,
    input  sida_pkg::t_dab_ctrl                 i_ctrl,
    input  logic [sida_pkg::VALUE_BITS-1:0]     i_value,
    output logic [sida_pkg::DIGIT_W-1:0]        o_digit
);

    logic [sida_pkg::VALUE_BITS-1:0] r_bin;
    logic [sida_pkg::VALUE_BITS-1:0] n_mag;
    logic [sida_pkg::BCD_W-1:0]      r_bcd;
    logic [sida_pkg::BCD_W-1:0]      n_adj;

    // two's complement magnitude, exact for the most negative value as unsigned
    assign n_mag = i_value[sida_pkg::VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    always_comb begin
        for (int d = 0; d < sida_pkg::DIGITS; d++) begin
            if (r_bcd[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] >= sida_pkg::DIGIT_W'(5)) begin
                n_adj[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
                    r_bcd[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] + sida_pkg::DIGIT_W'(3);
            end else begin
                n_adj[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
                    r_bcd[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.load) begin
            r_bin <= n_mag;
            r_bcd <= '0;
        end else if (i_ctrl.shift) begin
            r_bin <= {r_bin[sida_pkg::VALUE_BITS-2:0], 1'b0};
            r_bcd <= {n_adj[sida_pkg::BCD_W-2:0], r_bin[sida_pkg::VALUE_BITS-1]};
        end else if (i_ctrl.emit) begin
            r_bcd <= {r_bcd[sida_pkg::BCD_W-sida_pkg::DIGIT_W-1:0],
                      {sida_pkg::DIGIT_W{1'b0}}};
        end
    end

    assign o_digit = r_bcd[sida_pkg::BCD_W-1 -: sida_pkg::DIGIT_W];

endmodule

[hw/rtl/sida_ctrl.sv]
// ----------------------------------------------------------------------------
// sida_ctrl: sequencer for one conversion
// Load, VALUE_BITS shift steps, optional sign, then one step per digit
// position with leading zeros suppressed.
// ----------------------------------------------------------------------------
module sida_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_sign,
    input  logic [sida_pkg::DIGIT_W-1:0] i_digit,
    output logic                o_busy,
    output sida_pkg::t_dab_ctrl o_dab,
    output sida_pkg::t_emit     o_emit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGS
    } t_state;

    t_state                     r_state;
    logic [sida_pkg::CNT_W-1:0] r_cnt;
    logic                       r_neg;
    logic                       r_seen;
    logic                       w_cnt_one;
    logic                       w_show;

    assign w_cnt_one = (r_cnt == sida_pkg::CNT_W'(1));
    // a digit shows if it is nonzero or a nonzero one has gone, and the final one always does
    assign w_show    = r_seen || (i_digit != '0) || w_cnt_one;

    assign o_busy     = (r_state != S_IDLE);
    assign o_dab.load  = (r_state == S_IDLE) && i_start;
    assign o_dab.shift = (r_state == S_CONV);
    assign o_dab.emit  = (r_state == S_DIGS);

    always_comb begin
        o_emit = '0;
        unique case (r_state)
            S_SIGN: begin
                o_emit.valid = 1'b1;
                o_emit.sign  = 1'b1;
            end
            S_DIGS: begin
                o_emit.valid = w_show;
                o_emit.last  = w_cnt_one;
            end
            S_IDLE, S_CONV: begin
                o_emit = '0;
            end
            default: o_emit = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CONV;
                        r_cnt   <= sida_pkg::CNT_W'(sida_pkg::VALUE_BITS);
                        r_neg   <= i_sign;
                        r_seen  <= 1'b0;
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (w_cnt_one) begin
                        r_state <= r_neg ? S_SIGN : S_DIGS;
                        r_cnt   <= sida_pkg::CNT_W'(sida_pkg::DIGITS);
                    end
                end
                S_SIGN: begin
                    r_state <= S_DIGS;
                end
                S_DIGS: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (w_show) begin
                        r_seen <= 1'b1;
                    end
                    if (w_cnt_one) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement value per item into its decimal characters.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one value. Its text then comes
// out one character per strobe, most significant first, '-' ahead of a
// negative value and no leading zeros; o_last marks the final character.
// The receiver cannot stall: every strobe must be taken in its cycle. Busy
// stays high for the whole item but its accepting cycle, so no new value is
// taken until the last character has been formed. The item runs through the
// bit-serial shift-and-add-3 pass, the sign step for a negative value, and
// the one-digit-per-cycle output shift; leading zero positions are stepped
// through with no strobe. Character, strobe and last flag are registered
// before they reach the outputs.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [sida_pkg::VALUE_BITS-1:0]  i_value,
    output logic                                    o_strobe,
    output logic [sida_pkg::CHAR_W-1:0]             o_character,
    output logic                                    o_last
);

    sida_pkg::t_dab_ctrl             w_dab;
    sida_pkg::t_emit                 w_emit;
    logic [sida_pkg::DIGIT_W-1:0]    w_digit;
    logic                            r_strobe;
    logic [sida_pkg::CHAR_W-1:0]     r_char;
    logic                            r_last;

    sida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sign  (i_value[sida_pkg::VALUE_BITS-1]),
        .i_digit (w_digit),
        .o_busy  (busy),
        .o_dab   (w_dab),
        .o_emit  (w_emit)
    );

    sida_dabble u_dabble (
        .i_clk   (i_clk),
        .i_ctrl  (w_dab),
        .i_value (i_value),
        .o_digit (w_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_emit.valid;
        end
        r_last <= w_emit.last;
        r_char <= w_emit.sign ? sida_pkg::ASCII_MINUS
                              : sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(w_digit);
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_character == sida_pkg::ASCII_MINUS) ||
                     ((o_character >= sida_pkg::ASCII_ZERO) &&
                      (o_character <= sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(9))))
        else $error("character out of range");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_character == sida_pkg::ASCII_MINUS)) |-> !o_last)
        else $error("sign flagged as final character");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("strobe straight after final character");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

endmodule

[tb/sida_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_checker: result checker for the decimal text converter
// Watches accepted values, works out each value's decimal text on its own
// and compares every strobed character and its last flag in order.
// ----------------------------------------------------------------------------
module sida_checker
    import sida_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  logic                          o_strobe,
    input  logic [CHAR_W-1:0]             o_character,
    input  logic                          o_last,
    output int                            fail_count,
    output int                            text_pending
);

    localparam int RADIX       = 10;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    t_text_char text_expected[$];
    int         reports = 0;

    // sign first, then digits most significant first; magnitude is taken
    // unsigned at the value width so the most negative value comes out whole
    task automatic queue_decimal_text(input logic [VALUE_BITS-1:0] value);
        logic                  negative;
        logic [VALUE_BITS-1:0] magnitude;
        logic [3:0]            digits[$];
        t_text_char            c;
        negative  = value[VALUE_BITS-1];
        magnitude = negative ? -value : value;
        do begin
            digits.push_front(4'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        if (negative) begin
            c.code = ASCII_MINUS;
            c.last = 1'b0;
            text_expected.push_back(c);
        end
        foreach (digits[i]) begin
            c.code = ASCII_ZERO + CHAR_W'(digits[i]);
            c.last = (i == digits.size() - 1);
            text_expected.push_back(c);
        end
    endtask

    always @(posedge i_clk) begin
        t_text_char want;
        int         errors;
        errors = 0;
        if (!i_rst_n) begin
            text_pending <= 0;
            fail_count   <= 0;
        end else begin
            if (start && !busy) begin
                queue_decimal_text(i_value);
            end
            if (o_strobe) begin
                if (text_expected.size() == 0) begin
                    errors = 1;
                    if (reports < REPORT_MAX) begin
                        $display("%0t: unexpected character %0d last %0b",
                                 $realtime, o_character, o_last);
                    end
                    reports++;
                end else begin
                    want = text_expected.pop_front();
                    if (want.code !== o_character || want.last !== o_last) begin
                        errors = 1;
                        if (reports < REPORT_MAX) begin
                            $display("%0t: character exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, want.code, o_character, want.last, o_last);
                        end
                        reports++;
                    end
                end
            end
            fail_count   <= fail_count + errors;
            text_pending <= text_expected.size();
        end
    end

endmodule

[tb/tb_signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii: testbench for the decimal text converter
// Sends corner values then random values in bursts with random gaps, drains
// the block now and then, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

    import sida_pkg::*;

    localparam int RANDOM_ITEMS = 390;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 60;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start   = 1'b0;
    logic                          busy;
    logic signed [VALUE_BITS-1:0]  i_value = '0;
    logic                          o_strobe;
    logic [CHAR_W-1:0]             o_character;
    logic                          o_last;
    int                            fail_count;
    int                            text_pending;
    int                            stall_cycles = 0;
    int                            burst_left   = 1;
    logic signed [VALUE_BITS-1:0]  corner_values [0:19];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    signed_int_to_decimal_ascii u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    sida_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_character  (o_character),
        .o_last       (o_last),
        .fail_count   (fail_count),
        .text_pending (text_pending)
    );

    // ends the run when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // leaves start high; the caller decides whether the next step idles
    task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
        i_value <= value;
        start   <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                start   <= 1'b0;
                i_value <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_text_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (text_pending != 0);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] random_value();
        logic signed [VALUE_BITS-1:0] v;
        int                           p;
        p = 1;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = $urandom >> $urandom_range(1, 31);
            3: begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            default: v = $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                              : 32'sh80000000 + $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 1)) begin
            v = -v;
        end
        return v;
    endfunction

    initial begin
        corner_values = '{
            0, 1, -1, 9, 10, -9, -10, 99, 100, 12345,
            -67890, 999999999, 1000000000, -1000000000, 32'sh7FFFFFFF,
            -32'sh7FFFFFFF, 32'sh80000000, 32'sh55555555, 32'shAAAAAAAA, 1234567890
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
            pace_sender();
        end
        wait_text_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_value(random_value());
            pace_sender();
            if (n % 137 == 136) begin
                wait_text_drained();
            end
        end

        wait_text_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[signed_int_to_decimal_ascii.f]
hw/rtl/sida_pkg.sv
hw/rtl/sida_dabble.sv
hw/rtl/sida_ctrl.sv
hw/rtl/signed_int_to_decimal_ascii.sv
tb/sida_checker.sv
tb/tb_signed_int_to_decimal_ascii.sv
